>>> rtl/cpsm_pkg.sv
// Shared types and constants for the capture period speed meter.
// Holds field widths, register reset values, register indexes and the arithmetic constants.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cpsm_pkg;

   // Field widths.
   localparam int unsigned CAP_W     = 16;
   localparam int unsigned PERIOD_W  = CAP_W + 1;
   localparam int unsigned REV_W     = 28;
   localparam int unsigned SPEED_W   = 25;
   localparam int unsigned RATIO_W   = 10;
   localparam int unsigned TOP_W     = 16;
   localparam int unsigned THRESH_W  = 24;
   localparam int unsigned CSR_W     = 24;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 2'd2;

   // Register reset values.
   localparam logic [RATIO_W-1:0]  RATIO_RST  = 10'd1;
   localparam logic [TOP_W-1:0]    TOP_RST    = 16'hFFFF;
   localparam logic [THRESH_W-1:0] THRESH_RST = 24'd150;

   // Default number of sensor pulses per motor revolution.
   localparam int unsigned PPR_DEFAULT = 6;

   // Plausibility: ticks per second of the capture counter.
   localparam int unsigned PLAUS_NUM = 10000000;
   localparam int unsigned PROD_W    = PERIOD_W + THRESH_W + 1;

   // Revolution rate numerator and the speed scaling 3.14 * 45 / 1000 = 1413 / 10000.
   localparam longint unsigned REV_NUM   = 1000000000;
   localparam int unsigned     REV_NUM_W = 30;
   localparam int unsigned     SPEED_NUM = 1413;
   localparam int unsigned     SPEED_DEN = 10000;

   // Divider of the revolution rate: the dividend is exactly the rate numerator.
   localparam int unsigned DVD_W  = REV_NUM_W;
   localparam int unsigned STEP_W = $clog2(DVD_W + 1);

   localparam logic [DVD_W-1:0] REV_DVD = DVD_W'(REV_NUM);

   // Speed scaling by a rounded-up reciprocal: for every rate below 2^28 the top bits of
   // rate * SPEED_RECIP above SPEED_SHIFT equal rate * 1413 / 10000, truncated.
   localparam int unsigned SPEED_SHIFT  = 42;
   localparam int unsigned RECIP_W      = 40;
   localparam int unsigned RECIP_HALF_W = RECIP_W / 2;
   localparam logic [RECIP_W-1:0] SPEED_RECIP =
      RECIP_W'(((64'(SPEED_NUM) << SPEED_SHIFT) + 64'(SPEED_DEN) - 64'd1) / 64'(SPEED_DEN));

   localparam logic [REV_W-1:0]   REV_MAX   = {REV_W{1'b1}};
   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

   // Depth of the queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [RATIO_W-1:0]  ratio;
      logic [TOP_W-1:0]    top;
      logic [THRESH_W-1:0] thresh;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/cpsm_fifo.sv
// Small register queue that carries periods from the front part to the back part.
// Uses cpsm_pkg for the default width and depth; both are parameters.
`default_nettype none

module cpsm_fifo
   import cpsm_pkg::*;
#(
   parameter int unsigned WIDTH = PERIOD_W,
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cpsm_div.sv
// Restoring divider of the back part: one quotient bit per cycle.
// Depends on cpsm_pkg for the dividend width and the step counter width.
`default_nettype none

module cpsm_div
   import cpsm_pkg::*;
#(
   parameter int unsigned DIV_W = PERIOD_W + 13
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DVD_W-1:0]  dividend,
   input  wire logic [DIV_W-1:0]  divisor,
   input  wire logic [STEP_W-1:0] steps,
   output logic                   done,
   output logic [DVD_W-1:0]       quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // The remainder stays below the divisor, so the trial value fits one extra bit.
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = '0;
         dsr_in  = divisor;
         dvd_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

>>> rtl/cpsm_front.sv
// Front part: pairs up captures, works out the period with counter wrap and screens it.
// Depends on cpsm_pkg; pushes plausible periods into the queue towards the back part.
`default_nettype none

module cpsm_front
   import cpsm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                req_push,
   input  wire logic [CAP_W-1:0]    req_capture_value,
   output logic                     req_full,
   output logic                     q_push,
   output logic [PERIOD_W-1:0]      q_data,
   input  wire logic                q_full
);

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_MULT,
      ST_CHECK
   } state_type;

   state_type           state_ff, state_in;
   logic                phase_ff, phase_in;
   logic [CAP_W-1:0]    first_ff, first_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PERIOD_W-1:0] period_calc;
   logic                accept;
   logic                pass;

   assign req_full = (state_ff != ST_ACCEPT);
   assign accept   = req_push && !req_full;
   assign q_data   = period_ff;

   // A request that is not later than the first capture has wrapped through the top value.
   always_comb begin
      if (req_capture_value > first_ff) begin
         period_calc = {1'b0, req_capture_value} - {1'b0, first_ff};
      end else begin
         period_calc = {1'b0, cfg.top} + PERIOD_W'(1) - {1'b0, first_ff}
                       + {1'b0, req_capture_value};
      end
   end

   // 10000000 / period > threshold exactly when (threshold + 1) * period <= 10000000.
   assign pass   = (period_ff != '0) && (prod_ff <= PROD_W'(PLAUS_NUM));
   assign q_push = (state_ff == ST_CHECK) && pass && !q_full;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      first_in  = first_ff;
      period_in = period_ff;
      prod_in   = prod_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               if (!phase_ff) begin
                  first_in = req_capture_value;
                  phase_in = 1'b1;
               end else begin
                  phase_in  = 1'b0;
                  period_in = period_calc;
                  state_in  = ST_MULT;
               end
            end
         end
         ST_MULT: begin
            prod_in  = PROD_W'(period_ff) * PROD_W'({1'b0, cfg.thresh} + 25'd1);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!pass || !q_full) begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         phase_ff <= 1'b0;
         first_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         first_ff <= first_in;
      end
      period_ff <= period_in;
      prod_ff   <= prod_in;
   end

endmodule

`default_nettype wire

>>> rtl/cpsm_back.sv
// Back part: turns a period into the revolution rate and the linear speed.
// Depends on cpsm_pkg and cpsm_div; holds the result register towards the rsp channel.
`default_nettype none

module cpsm_back
   import cpsm_pkg::*;
#(
   parameter int unsigned PULSES_PER_REV = PPR_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [RATIO_W-1:0]  ratio,
   input  wire logic                q_empty,
   input  wire logic [PERIOD_W-1:0] q_data,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [PERIOD_W-1:0]      rsp_period_ticks,
   output logic [REV_W-1:0]         rsp_rev_rate_milli,
   output logic [SPEED_W-1:0]       rsp_linear_speed
);

   localparam int unsigned K_W   = $clog2(PULSES_PER_REV * ((1 << RATIO_W) - 1) + 1);
   localparam int unsigned DIV_W = PERIOD_W + K_W;
   localparam logic [K_W-1:0] PPR_K = K_W'(PULSES_PER_REV);

   localparam int unsigned PART_W = REV_W + RECIP_HALF_W;
   localparam int unsigned SUM_W  = PART_W + RECIP_HALF_W;
   localparam int unsigned SQ_W   = SUM_W - SPEED_SHIFT;
   localparam logic [RECIP_HALF_W-1:0] RECIP_LO = SPEED_RECIP[RECIP_HALF_W-1:0];
   localparam logic [RECIP_HALF_W-1:0] RECIP_HI = SPEED_RECIP[RECIP_W-1:RECIP_HALF_W];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_REV_GO,
      ST_REV_WAIT,
      ST_SPD_LO,
      ST_SPD_HI,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic [DIV_W-1:0]    dsr_ff, dsr_in;
   logic [REV_W-1:0]    rev_ff, rev_in;
   logic [PART_W-1:0]   part_ff, part_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;
   logic                out_valid_ff, out_valid_in;
   logic [PERIOD_W-1:0] out_period_ff, out_period_in;
   logic [REV_W-1:0]    out_rev_ff, out_rev_in;
   logic [SPEED_W-1:0]  out_speed_ff, out_speed_in;
   logic [RATIO_W-1:0]  ratio_eff;
   logic                div_start;
   logic [DVD_W-1:0]    div_dividend;
   logic [DIV_W-1:0]    div_divisor;
   logic [STEP_W-1:0]   div_steps;
   logic                div_done;
   logic [DVD_W-1:0]    div_quo;
   logic                out_free;
   logic [PART_W-1:0]   hi_part;
   logic [SUM_W-1:0]    spd_sum;
   logic [SQ_W-1:0]     spd_quo;

   // A ratio of zero counts as one.
   assign ratio_eff = (ratio == '0) ? RATIO_W'(1) : ratio;

   assign rsp_empty          = !out_valid_ff;
   assign rsp_period_ticks   = out_period_ff;
   assign rsp_rev_rate_milli = out_rev_ff;
   assign rsp_linear_speed   = out_speed_ff;
   assign out_free           = !out_valid_ff || rsp_pop;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign div_start = (state_ff == ST_REV_GO);

   // The divider works out 1e9 over period times pulses times ratio.
   assign div_dividend = REV_DVD;
   assign div_divisor  = dsr_ff;
   assign div_steps    = STEP_W'(REV_NUM_W);

   // The reciprocal product is built from two half-width partial products.
   assign hi_part = PART_W'(rev_ff) * PART_W'(RECIP_HI);
   assign spd_sum = {hi_part, {RECIP_HALF_W{1'b0}}} + SUM_W'(part_ff);
   assign spd_quo = spd_sum[SUM_W-1:SPEED_SHIFT];

   cpsm_div #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      k_in          = k_ff;
      dsr_in        = dsr_ff;
      rev_in        = rev_ff;
      part_in       = part_ff;
      speed_in      = speed_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_period_in = out_period_ff;
      out_rev_in    = out_rev_ff;
      out_speed_in  = out_speed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               period_in = q_data;
               k_in      = K_W'(ratio_eff) * PPR_K;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            dsr_in   = DIV_W'(period_ff) * DIV_W'(k_ff);
            state_in = ST_REV_GO;
         end
         ST_REV_GO: begin
            state_in = ST_REV_WAIT;
         end
         ST_REV_WAIT: begin
            if (div_done) begin
               rev_in   = (div_quo > DVD_W'(REV_MAX)) ? REV_MAX : div_quo[REV_W-1:0];
               state_in = ST_SPD_LO;
            end
         end
         ST_SPD_LO: begin
            part_in  = PART_W'(rev_ff) * PART_W'(RECIP_LO);
            state_in = ST_SPD_HI;
         end
         ST_SPD_HI: begin
            speed_in = (spd_quo > SQ_W'(SPEED_MAX)) ? SPEED_MAX : spd_quo[SPEED_W-1:0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_period_in = period_ff;
               out_rev_in    = rev_ff;
               out_speed_in  = speed_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      period_ff     <= period_in;
      k_ff          <= k_in;
      dsr_ff        <= dsr_in;
      rev_ff        <= rev_in;
      part_ff       <= part_in;
      speed_ff      <= speed_in;
      out_period_ff <= out_period_in;
      out_rev_ff    <= out_rev_in;
      out_speed_ff  <= out_speed_in;
   end

endmodule

`default_nettype wire

>>> rtl/capture_period_speed_meter.sv
// Top level of the capture period speed meter: configuration registers and the two parts.
// Depends on cpsm_pkg, cpsm_front, cpsm_fifo and cpsm_back.
//
// Use: each request on the req channel (req_push while req_full is low) carries one counter
// value latched at a rising edge. Requests are taken in pairs; the second of a pair gives the
// period in counter ticks, wrapping through the top value. A pair whose period is zero or
// too long for the plausibility threshold yields no response; any other pair yields one
// response on the rsp channel (shown while rsp_empty is low, taken with rsp_pop).
// The first request of a pair is only stored. After the second, the front part multiplies
// the period by the threshold plus one and checks it, then the period waits in a two-entry
// queue. The back part takes one period at a time: it scales the period, runs the
// bit-serial divider of the revolution rate (30 steps), then does the speed scaling as a
// reciprocal multiplication in the states ST_SPD_LO and ST_SPD_HI. The front part can take
// further pairs while the back part is busy, as long as the queue has room.
// If the receiver does not pop, the finished response is held; the back part completes one
// more period and the queue fills, after which req_full stays high after the next pair.
// Synchronous reset empties the queue and response register, restarts pairing and restores
// the configuration registers to their defaults. csr_wr_en writes a register at once.
`default_nettype none

module capture_period_speed_meter
   import cpsm_pkg::*;
#(
   parameter int unsigned PULSES_PER_REV = PPR_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic [CAP_W-1:0]     req_capture_value,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [PERIOD_W-1:0]       rsp_period_ticks,
   output logic [REV_W-1:0]          rsp_rev_rate_milli,
   output logic [SPEED_W-1:0]        rsp_linear_speed,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cfg_type             cfg_ff, cfg_in;
   logic                q_push;
   logic [PERIOD_W-1:0] q_push_data;
   logic                q_full;
   logic                q_pop;
   logic [PERIOD_W-1:0] q_pop_data;
   logic                q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RATIO:  cfg_in.ratio  = csr_wdata[RATIO_W-1:0];
            CSR_TOP:    cfg_in.top    = csr_wdata[TOP_W-1:0];
            CSR_THRESH: cfg_in.thresh = csr_wdata[THRESH_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ratio  <= RATIO_RST;
         cfg_ff.top    <= TOP_RST;
         cfg_ff.thresh <= THRESH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpsm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_push          (req_push),
      .req_capture_value (req_capture_value),
      .req_full          (req_full),
      .q_push            (q_push),
      .q_data            (q_push_data),
      .q_full            (q_full)
   );

   cpsm_fifo #(
      .WIDTH (PERIOD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   cpsm_back #(
      .PULSES_PER_REV (PULSES_PER_REV)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .ratio              (cfg_ff.ratio),
      .q_empty            (q_empty),
      .q_data             (q_pop_data),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_period_ticks   (rsp_period_ticks),
      .rsp_rev_rate_milli (rsp_rev_rate_milli),
      .rsp_linear_speed   (rsp_linear_speed)
   );

endmodule

`default_nettype wire

>>> rtl/cpsm_checker.sv
// Port-level checks for the capture period speed meter, bound to the top level.
// Depends on cpsm_pkg for field widths; sees only the top level's ports.
`default_nettype none

module cpsm_port_checker
   import cpsm_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_full,
   input wire logic                 rsp_empty,
   input wire logic                 rsp_pop,
   input wire logic [PERIOD_W-1:0]  rsp_period_ticks,
   input wire logic [REV_W-1:0]     rsp_rev_rate_milli,
   input wire logic [SPEED_W-1:0]   rsp_linear_speed
);

   // Reset leaves no response waiting.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response shown straight after reset");

   // Reset leaves the block ready for the first request of a pair.
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("block not ready after reset");

   // A response that is not taken stays with the same values.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_period_ticks)
         && $stable(rsp_rev_rate_milli) && $stable(rsp_linear_speed)))
      else $error("waiting response changed or vanished");

   // Zero periods are dropped, so every response has a nonzero period.
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_period_ticks != '0))
      else $error("response with zero period");

   // The speed scale is below one; rates above SPEED_MAX are not checked.
   a_speed_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (SPEED_W'(rsp_linear_speed) <= SPEED_W'(rsp_rev_rate_milli)
         || rsp_rev_rate_milli > REV_W'(SPEED_MAX)))
      else $error("linear speed exceeds revolution rate");

endmodule

bind capture_period_speed_meter cpsm_port_checker u_cpsm_port_checker (.*);

`default_nettype wire
